/* rtl/core/msb_first_bit_reader_defines.svh */
// Assertion macros for the bit reader. Each expects clk and rst_n in scope.
`ifndef MSB_FIRST_BIT_READER_DEFINES_SVH
`define MSB_FIRST_BIT_READER_DEFINES_SVH

// Same-cycle implication
`define MBR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mbr_pkg.sv */
`default_nettype none

package mbr_pkg;

    // Default store depth in bytes
    localparam int STORE_BYTES_DEF = 4096;

    // Widest field a get or show can return
    localparam int MAX_BITS = 32;

    // Operation codes
    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_GET     = 3'd1,
        OP_SHOW    = 3'd2,
        OP_ALIGN   = 3'd3,
        OP_BACK    = 3'd4,
        OP_RESTART = 3'd5
    } op_t;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_WIDE = 2'd1,
        ERR_SHORT    = 2'd2,
        ERR_FULL     = 2'd3
    } err_t;

    // Control of the byte-serial accumulator
    typedef struct packed {
        logic       clear;  // empty the accumulator
        logic       shift;  // take one byte from the store
        logic       first;  // byte is the first of the field
        logic [2:0] lead;   // bits of the first byte already read
        logic [2:0] shamt;  // trailing bits to drop at the end
    } shift_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/msb_first_bit_reader.sv */
`default_nettype none

// Bit reader over a byte store, most significant bit first. Bytes are
// appended one per word; get and show then return up to 32 bits from the
// current position, and align, go back and restart move the position.
// Each input word gives exactly one output word. A get or show that reads
// data moves from evaluate through read and drain to done; the field spans
// 1 to 5 stored bytes, and the byte memory delivers one byte per cycle into
// a shift accumulator, so a 32-bit field at a nonzero bit offset spans 5
// bytes. Every other word goes from evaluate straight to done. One word is
// worked on at a time; the next is taken as soon as the result sits in the
// output register, even if it has not yet been taken. A result waits in
// done while the output register still holds an untaken result.

module msb_first_bit_reader
    import mbr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  op,
    input  wire logic [5:0]  bit_count,
    input  wire logic [12:0] byte_count,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      value,
    output logic [1:0]       error_code,
    output logic [31:0]      bits_consumed,
    output logic [15:0]      bits_left
);

`include "msb_first_bit_reader_defines.svh"

    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = $clog2(STORE_BYTES + 1);
    localparam int LW = PW + 3;
    localparam int CW = (PW > 13) ? PW : 13;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_READ  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Latched input word
    logic [2:0]  op_reg;
    logic [5:0]  count_reg;
    logic [12:0] back_reg;
    logic [7:0]  data_reg;

    // Reader state
    logic [PW-1:0] len_reg, len_next;
    logic [PW-1:0] bp_reg, bp_next;
    logic [2:0]    bitp_reg, bitp_next;
    logic [31:0]   total_reg, total_next;

    // Read sequencer
    logic [PW-1:0] addr_reg, addr_next;
    logic [2:0]    left_reg, left_next;
    logic          rd_valid_reg;
    logic          first_reg, first_next;
    logic [2:0]    lead_reg, lead_next;
    logic [2:0]    shamt_reg, shamt_next;
    logic          read_ok_reg, read_ok_next;
    logic [1:0]    err_reg, err_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] value_reg;
    logic [1:0]  error_code_reg;
    logic [31:0] bits_consumed_reg;
    logic [15:0] bits_left_reg;

    logic              accept;
    logic              out_load;
    logic [LW-1:0]     rem;
    logic [6:0]        field_end;
    logic [6:0]        span_bytes;
    logic [CW-1:0]     back_ext;
    logic [CW-1:0]     bp_ext;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic              rd_en;
    logic [MAX_BITS-1:0] sh_value;
    shift_ctrl_t       sh_ctrl;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Bits still unread
    assign rem = {(len_reg - bp_reg), 3'b000} - LW'(bitp_reg);

    // Field geometry for get and show
    assign field_end  = 7'(bitp_reg) + 7'(count_reg);
    assign span_bytes = (field_end + 7'd7) >> 3;

    assign back_ext = CW'(back_reg);
    assign bp_ext   = CW'(bp_reg);

    // Byte store
    assign wr_en = (state_reg == S_EVAL) && (op_reg == OP_LOAD)
                   && (len_reg < PW'(STORE_BYTES));
    assign rd_en = (state_reg == S_READ);

    mbr_store #(
        .STORE_BYTES(STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[AW-1:0]),
        .wr_data (data_reg),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Byte-serial accumulator
    always_comb
    begin
        sh_ctrl.clear = (state_reg == S_EVAL);
        sh_ctrl.shift = rd_valid_reg;
        sh_ctrl.first = first_reg;
        sh_ctrl.lead  = lead_reg;
        sh_ctrl.shamt = shamt_reg;
    end

    mbr_shift u_shift (
        .clk   (clk),
        .ctrl  (sh_ctrl),
        .din   (rd_data),
        .value (sh_value)
    );

    // Sequencer and reader state update
    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        bp_next      = bp_reg;
        bitp_next    = bitp_reg;
        total_next   = total_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        first_next   = first_reg;
        lead_next    = lead_reg;
        shamt_next   = shamt_reg;
        read_ok_next = read_ok_reg;
        err_next     = err_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                err_next     = ERR_NONE;
                read_ok_next = 1'b0;
                state_next   = S_DONE;
                case (op_reg)
                    OP_LOAD:
                    begin
                        if (len_reg >= PW'(STORE_BYTES))
                        begin
                            err_next = ERR_FULL;
                        end
                        else
                        begin
                            len_next = len_reg + PW'(1);
                        end
                    end

                    OP_GET, OP_SHOW:
                    begin
                        if (count_reg == 6'd0)
                        begin
                            err_next = ERR_NONE;
                        end
                        else if (count_reg > 6'(MAX_BITS))
                        begin
                            err_next = ERR_TOO_WIDE;
                        end
                        else if (LW'(count_reg) > rem)
                        begin
                            err_next = ERR_SHORT;
                        end
                        else
                        begin
                            read_ok_next = 1'b1;
                            addr_next    = bp_reg;
                            left_next    = span_bytes[2:0];
                            first_next   = 1'b1;
                            lead_next    = bitp_reg;
                            shamt_next   = 3'(3'd0 - field_end[2:0]);
                            state_next   = S_READ;
                            // Position moves now; the read uses the latched address
                            if (op_reg == OP_GET)
                            begin
                                bp_next    = bp_reg + PW'(field_end[6:3]);
                                bitp_next  = field_end[2:0];
                                total_next = total_reg + 32'(count_reg);
                            end
                        end
                    end

                    OP_ALIGN:
                    begin
                        if (bitp_reg != 3'd0)
                        begin
                            bp_next    = bp_reg + PW'(1);
                            bitp_next  = 3'd0;
                            total_next = total_reg + 32'(4'd8 - {1'b0, bitp_reg});
                        end
                    end

                    OP_BACK:
                    begin
                        if (back_ext >= bp_ext)
                        begin
                            bp_next = '0;
                        end
                        else
                        begin
                            bp_next = PW'(bp_ext - back_ext);
                        end
                    end

                    OP_RESTART:
                    begin
                        len_next   = '0;
                        bp_next    = '0;
                        bitp_next  = 3'd0;
                        total_next = '0;
                    end

                    default:
                    begin
                        err_next = ERR_NONE;
                    end
                endcase
            end

            S_READ:
            begin
                addr_next = addr_reg + PW'(1);
                left_next = left_reg - 3'd1;
                if (left_reg == 3'd1)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // First byte mask only applies to the first shifted byte
        if (rd_valid_reg)
        begin
            first_next = 1'b0;
        end
    end

    // Output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            bp_reg        <= '0;
            bitp_reg      <= 3'd0;
            total_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            bp_reg        <= bp_next;
            bitp_reg      <= bitp_next;
            total_reg     <= total_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            count_reg <= bit_count;
            back_reg  <= byte_count;
            data_reg  <= data_byte;
        end
        addr_reg    <= addr_next;
        left_reg    <= left_next;
        first_reg   <= first_next;
        lead_reg    <= lead_next;
        shamt_reg   <= shamt_next;
        read_ok_reg <= read_ok_next;
        err_reg     <= err_next;
        if (out_load)
        begin
            value_reg         <= read_ok_reg ? sh_value : 32'd0;
            error_code_reg    <= err_reg;
            bits_consumed_reg <= total_reg;
            bits_left_reg     <= 16'(rem);
        end
    end

    assign out_valid     = out_valid_reg;
    assign value         = value_reg;
    assign error_code    = error_code_reg;
    assign bits_consumed = bits_consumed_reg;
    assign bits_left     = bits_left_reg;

    // Checks
    `MBR_ASSERT_NOW(a_pos_in_store, 1'b1,
        (bp_reg < len_reg) || ((bp_reg == len_reg) && (bitp_reg == 3'd0)),
        "read position beyond stored data")
    `MBR_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= PW'(STORE_BYTES),
        "store length beyond depth")
    `MBR_ASSERT_NOW(a_read_in_store, state_reg == S_READ, addr_reg < len_reg,
        "byte read beyond stored data")
    `MBR_ASSERT_NEXT(a_result_shown, out_load, out_valid_reg && (state_reg == S_IDLE),
        "result not presented after completion")

endmodule

`default_nettype wire

/* rtl/core/mbr_store.sv */
`default_nettype none

module mbr_store
    import mbr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    localparam int AW = $clog2(STORE_BYTES)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    // Byte memory, one write and one registered read per cycle
    logic [7:0] mem [STORE_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mbr_shift.sv */
`default_nettype none

module mbr_shift
    import mbr_pkg::*;
(
    input  wire logic        clk,
    input  wire shift_ctrl_t ctrl,
    input  wire logic [7:0]  din,
    output logic [MAX_BITS-1:0] value
);

    // Five bytes at most: 32 bits at a nonzero bit offset
    localparam int AccW = MAX_BITS + 8;

    logic [AccW-1:0] acc_reg;
    logic [AccW-1:0] acc_next;
    logic [7:0]      byte_in;
    logic [AccW-1:0] aligned;

    // Drop bits of the first byte that lie before the field
    always_comb
    begin
        byte_in = din;
        if (ctrl.first)
        begin
            byte_in = din & (8'hFF >> ctrl.lead);
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.shift)
        begin
            acc_next = {acc_reg[AccW-9:0], byte_in};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Right align: drop the bits after the field
    assign aligned = acc_reg >> ctrl.shamt;
    assign value   = aligned[MAX_BITS-1:0];

endmodule

`default_nettype wire

/* dv/msb_first_bit_reader_tb.sv */
`timescale 1ns / 1ps

module msb_first_bit_reader_tb;
    import mbr_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int QUIET_LIMIT = 2000;   // cycles with no word moving on either side
    localparam int LONG_HOLD   = 400;    // receiver hold-off to back the block up
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_WORDS = 1075;

    // Op codes the block leaves undecoded
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // One result word
    typedef struct {
        logic [31:0] value;
        err_t        err;
        logic [31:0] consumed;
        logic [15:0] left;
    } reading_t;

    // One row of the directed script
    typedef struct {
        logic [2:0]  code;
        logic [5:0]  cnt;
        logic [12:0] back;
        logic [7:0]  data;
        bit          typed_in;
        reading_t    want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = '0;
    logic [5:0]  bit_count = '0;
    logic [12:0] byte_count = '0;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] value;
    logic [1:0]  error_code;
    logic [31:0] bits_consumed;
    logic [15:0] bits_left;

    // Shadow of the reader state
    logic [7:0]  shadow_store [STORE_BYTES_DEF];
    int unsigned shadow_len = 0;
    int unsigned shadow_byte_ptr = 0;
    int unsigned shadow_bit_ptr = 0;
    logic [31:0] shadow_consumed = '0;

    reading_t    pending_readings [$];
    script_row_t script [$];

    int mismatches = 0;
    int words_sent = 0;
    int readings_checked = 0;
    int quiet_cycles = 0;
    int send_calm = 0;
    int take_calm = 0;
    int errs_seen [4] = '{0, 0, 0, 0};

    msb_first_bit_reader dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .bit_count     (bit_count),
        .byte_count    (byte_count),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .value         (value),
        .error_code    (error_code),
        .bits_consumed (bits_consumed),
        .bits_left     (bits_left)
    );

    always #CLK_HALF clk = ~clk;

    // Bits still unread in the shadow store
    function automatic int unsigned unread_bits();
        return ((shadow_len - shadow_byte_ptr) << 3) - shadow_bit_ptr;
    endfunction

    function automatic void take_bits(input int unsigned n);
        int unsigned pos;
        pos = shadow_bit_ptr + n;
        shadow_byte_ptr += pos >> 3;
        shadow_bit_ptr = pos & 7;
        shadow_consumed += n;
    endfunction

    // Apply one accepted word to the shadow state and return its reading
    function automatic reading_t predict_reading(input logic [2:0] code, input logic [5:0] cnt,
                                                 input logic [12:0] back, input logic [7:0] data);
        reading_t    r;
        int unsigned pos;
        int unsigned idx;
        r.value = '0;
        r.err = ERR_NONE;
        case (code)
            OP_LOAD:
            begin
                if (shadow_len >= STORE_BYTES_DEF)
                begin
                    r.err = ERR_FULL;
                end
                else
                begin
                    shadow_store[shadow_len] = data;
                    shadow_len++;
                end
            end
            OP_GET, OP_SHOW:
            begin
                if (cnt > MAX_BITS)
                begin
                    r.err = ERR_TOO_WIDE;
                end
                else if (cnt > unread_bits())
                begin
                    r.err = ERR_SHORT;
                end
                else if (cnt != 0)
                begin
                    // msb first, crossing byte boundaries as needed
                    pos = shadow_bit_ptr;
                    for (int i = 0; i < cnt; i++)
                    begin
                        idx = shadow_byte_ptr + (pos >> 3);
                        r.value = {r.value[30:0], shadow_store[idx][7 - (pos & 7)]};
                        pos++;
                    end
                    if (code == OP_GET)
                        take_bits(cnt);
                end
            end
            OP_ALIGN:
            begin
                if (shadow_bit_ptr != 0)
                    take_bits(8 - shadow_bit_ptr);
            end
            OP_BACK:
            begin
                if (back >= shadow_byte_ptr)
                    shadow_byte_ptr = 0;
                else
                    shadow_byte_ptr -= back;
            end
            OP_RESTART:
            begin
                shadow_len = 0;
                shadow_byte_ptr = 0;
                shadow_bit_ptr = 0;
                shadow_consumed = '0;
            end
            default:
            begin
            end
        endcase
        r.consumed = shadow_consumed;
        r.left = 16'(unread_bits());
        return r;
    endfunction

    // Gap before the next word or ready: mostly short, a few long, calm stretches
    function automatic int next_gap(inout int calm_left);
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Bit counts: mostly within what is unread, some zero, too wide or short
    function automatic logic [5:0] pick_count();
        int unsigned roll;
        int unsigned left;
        roll = $urandom_range(0, 99);
        left = unread_bits();
        if (roll < 78 && left > 0)
            return 6'($urandom_range(1, (left < MAX_BITS) ? left : MAX_BITS));
        if (roll < 84)
            return (roll & 1) ? 6'd0 : 6'(MAX_BITS);
        if (roll < 92)
            return 6'($urandom_range(MAX_BITS + 1, 63));
        return 6'($urandom_range(0, MAX_BITS));
    endfunction

    function automatic logic [12:0] pick_back();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 13'($urandom_range(0, 4));
        if (roll < 90)
            return 13'($urandom_range(0, 64));
        return 13'($urandom_range(0, 8191));
    endfunction

    function automatic logic [2:0] pick_read_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return OP_GET;
        if (roll < 80)
            return OP_SHOW;
        if (roll < 90)
            return OP_ALIGN;
        return OP_BACK;
    endfunction

    // Offer one word, hold it until taken, then queue its reading
    task automatic offer_word(input logic [2:0] code, input logic [5:0] cnt,
                              input logic [12:0] back, input logic [7:0] data,
                              input bit typed_in, input reading_t want);
        int       gap;
        reading_t predicted;
        gap = next_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= code;
        bit_count  <= cnt;
        byte_count <= back;
        data_byte  <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_reading(code, cnt, back, data);
        pending_readings.push_back(typed_in ? want : predicted);
        words_sent++;
    endtask

    task automatic offer_random(input logic [2:0] code, input logic [5:0] cnt,
                                input logic [12:0] back);
        reading_t none;
        none.value = '0;
        none.err = ERR_NONE;
        none.consumed = '0;
        none.left = '0;
        offer_word(code, cnt, back, 8'($urandom_range(0, 255)), 1'b0, none);
    endtask

    // Sender stops offering until every reading has come back
    task automatic drain_readings();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [2:0] code, input logic [5:0] cnt,
                           input logic [12:0] back, input logic [7:0] data,
                           input bit typed_in, input logic [31:0] v, input err_t e,
                           input logic [31:0] c, input logic [15:0] l);
        script_row_t row;
        row.code = code;
        row.cnt = cnt;
        row.back = back;
        row.data = data;
        row.typed_in = typed_in;
        row.want.value = v;
        row.want.err = e;
        row.want.consumed = c;
        row.want.left = l;
        script.push_back(row);
    endtask

    // Mostly load-then-read sequences, with noise, restarts and rewinds
    task automatic random_words(input int quota);
        int start;
        int roll;
        int k;
        start = words_sent;
        while (words_sent - start < quota)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 68)
            begin
                k = $urandom_range(1, 10);
                repeat (k) offer_random(OP_LOAD, pick_count(), pick_back());
                k = $urandom_range(1, 8);
                repeat (k) offer_random(pick_read_op(), pick_count(), pick_back());
            end
            else if (roll < 88)
            begin
                offer_random(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                             13'($urandom_range(0, 8191)));
            end
            else if (roll < 93)
            begin
                offer_random(OP_RESTART, pick_count(), pick_back());
            end
            else if (roll < 99)
            begin
                offer_random(OP_BACK, pick_count(), pick_back());
                k = $urandom_range(1, 6);
                repeat (k) offer_random(pick_read_op(), pick_count(), pick_back());
            end
            else
            begin
                drain_readings();
            end
        end
    endtask

    // Result side: compare each reading with the oldest expectation
    always @(posedge clk)
    begin
        reading_t w;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (out_valid && out_ready)
            begin
                errs_seen[error_code]++;
                if (pending_readings.size() == 0)
                begin
                    $error("reading with none expected: value %0h, error_code %0d",
                           value, error_code);
                    mismatches++;
                end
                else
                begin
                    w = pending_readings.pop_front();
                    readings_checked++;
                    if (value !== w.value)
                    begin
                        $error("value: expected %0h, got %0h", w.value, value);
                        mismatches++;
                    end
                    if (error_code !== w.err)
                    begin
                        $error("error_code: expected %0d, got %0d", w.err, error_code);
                        mismatches++;
                    end
                    if (bits_consumed !== w.consumed)
                    begin
                        $error("bits_consumed: expected %0d, got %0d", w.consumed,
                               bits_consumed);
                        mismatches++;
                    end
                    if (bits_left !== w.left)
                    begin
                        $error("bits_left: expected %0d, got %0d", w.left, bits_left);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Receiver: random ready gaps, plus long hold-offs that back the block up
    initial
    begin : receiver
        int gap;
        int burst;
        int cycles;
        int holds_done;
        cycles = 0;
        holds_done = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ((cycles > 1500 && holds_done == 0) || (cycles > 30000 && holds_done == 1))
            begin
                gap = LONG_HOLD;
                holds_done++;
            end
            else
            begin
                gap = next_gap(take_calm);
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                cycles += gap;
            end
            out_ready <= 1'b1;
            burst = $urandom_range(1, 12);
            repeat (burst) @(posedge clk);
            cycles += burst;
        end
    end

    // Watchdog: nothing moving for too long ends the run
    initial
    begin : watchdog
        wait (rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("msb_first_bit_reader regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script: empty store, count limits, spare codes, then a
        // small known stream read across byte boundaries
        add_row(OP_SHOW,      6'd8,  13'd0,    8'h00, 1, 32'h0, ERR_SHORT,    32'd0, 16'd0);
        add_row(OP_GET,       6'd0,  13'd0,    8'h00, 1, 32'h0, ERR_NONE,     32'd0, 16'd0);
        add_row(OP_GET,       6'd33, 13'd0,    8'h00, 1, 32'h0, ERR_TOO_WIDE, 32'd0, 16'd0);
        add_row(OP_SHOW,      6'd63, 13'd0,    8'h00, 1, 32'h0, ERR_TOO_WIDE, 32'd0, 16'd0);
        add_row(OP_ALIGN,     6'd0,  13'd0,    8'h00, 1, 32'h0, ERR_NONE,     32'd0, 16'd0);
        add_row(OP_BACK,      6'd0,  13'd8191, 8'h00, 1, 32'h0, ERR_NONE,     32'd0, 16'd0);
        add_row(OP_SPARE_LO,  6'd63, 13'd8191, 8'hFF, 1, 32'h0, ERR_NONE,     32'd0, 16'd0);
        add_row(OP_SPARE_HI,  6'd32, 13'd4096, 8'hFF, 1, 32'h0, ERR_NONE,     32'd0, 16'd0);
        add_row(OP_LOAD,      6'd0,  13'd0,    8'hFF, 1, 32'h0, ERR_NONE,     32'd0, 16'd8);
        add_row(OP_LOAD,      6'd0,  13'd0,    8'h00, 1, 32'h0, ERR_NONE,     32'd0, 16'd16);
        add_row(OP_LOAD,      6'd0,  13'd0,    8'hA5, 1, 32'h0, ERR_NONE,     32'd0, 16'd24);
        add_row(OP_LOAD,      6'd0,  13'd0,    8'h5A, 1, 32'h0, ERR_NONE,     32'd0, 16'd32);
        add_row(OP_LOAD,      6'd0,  13'd0,    8'h80, 1, 32'h0, ERR_NONE,     32'd0, 16'd40);
        add_row(OP_SHOW,      6'd32, 13'd0,    8'h00, 1, 32'hFF00A55A, ERR_NONE, 32'd0, 16'd40);
        add_row(OP_GET,       6'd1,  13'd0,    8'h00, 1, 32'h1, ERR_NONE,     32'd1, 16'd39);
        add_row(OP_GET,       6'd32, 13'd0,    8'h00, 0, 32'h0, ERR_NONE,     32'd0, 16'd0);
        add_row(OP_GET,       6'd8,  13'd0,    8'h00, 1, 32'h0, ERR_SHORT,    32'd33, 16'd7);
        add_row(OP_ALIGN,     6'd0,  13'd0,    8'h00, 1, 32'h0, ERR_NONE,     32'd40, 16'd0);
        add_row(OP_BACK,      6'd0,  13'd2,    8'h00, 1, 32'h0, ERR_NONE,     32'd40, 16'd16);
        add_row(OP_BACK,      6'd0,  13'd4096, 8'h00, 1, 32'h0, ERR_NONE,     32'd40, 16'd40);
        add_row(OP_SHOW,      6'd0,  13'd0,    8'h00, 1, 32'h0, ERR_NONE,     32'd40, 16'd40);
        add_row(OP_GET,       6'd5,  13'd0,    8'h00, 0, 32'h0, ERR_NONE,     32'd0, 16'd0);
        add_row(OP_ALIGN,     6'd0,  13'd0,    8'h00, 0, 32'h0, ERR_NONE,     32'd0, 16'd0);
        add_row(OP_RESTART,   6'd0,  13'd0,    8'h00, 1, 32'h0, ERR_NONE,     32'd0, 16'd0);
        add_row(OP_GET,       6'd1,  13'd0,    8'h00, 1, 32'h0, ERR_SHORT,    32'd0, 16'd0);
        foreach (script[r])
            offer_word(script[r].code, script[r].cnt, script[r].back, script[r].data,
                       script[r].typed_in, script[r].want);
        drain_readings();

        random_words(RANDOM_WORDS);
        drain_readings();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d words and %0d readings over loads, reads, rewinds and restarts",
                 words_sent, readings_checked);
        $display("errors returned: too wide %0d, short %0d, full %0d",
                 errs_seen[ERR_TOO_WIDE], errs_seen[ERR_SHORT], errs_seen[ERR_FULL]);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("msb_first_bit_reader regression: pass");
        else
            $display("msb_first_bit_reader regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/mbr_pkg.sv
rtl/core/mbr_store.sv
rtl/core/mbr_shift.sv
rtl/core/msb_first_bit_reader.sv
dv/msb_first_bit_reader_tb.sv
